@@ hw/rtl/cft_pkg.sv @@
// Shared types and constants of the CSV field tokenizer.
// No dependencies; every RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cft_pkg;

    localparam int MAX_LEN = 256;
    localparam int FL_W = 9;
    localparam int LEN_NEED = $clog2(MAX_LEN + 1);
    localparam int LEN_W = (LEN_NEED > FL_W) ? LEN_NEED : FL_W;

    localparam logic [7:0] QUOTE_BYTE = 8'd34;
    localparam logic [7:0] NUL_BYTE = 8'd0;
    localparam logic [7:0] CR_BYTE = 8'd13;
    localparam logic [7:0] LF_BYTE = 8'd10;
    localparam logic [7:0] SEP_RESET = 8'd44;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_LINE = 2'd1;
    localparam logic [1:0] ST_QUOTE = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    typedef struct packed {
        logic [7:0] text;
        logic       line_end;
        logic       quote;
        logic       sep;
    } t_class;

    typedef struct packed {
        logic            kind;
        logic [7:0]      field_byte;
        logic [1:0]      status;
        logic [FL_W-1:0] field_length;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

@@ hw/rtl/cft_front.sv @@
// Front end: input transfer, separator register and byte classification.
// Depends on cft_pkg; feeds cft_queue.
`timescale 1ns / 1ps
`default_nettype none

module cft_front
    import cft_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_separator,
    input  wire t_q_status  i_q_status,
    output logic            o_q_wr,
    output t_class          o_q_data
);

    logic [7:0] r_sep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
        end else if (i_cfg_valid) begin
            r_sep <= i_cfg_separator;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign full = i_q_status.full;
    assign o_q_wr = push & ~i_q_status.full;

    always_comb begin
        o_q_data.text = i_text_byte;
        o_q_data.line_end = (i_text_byte == NUL_BYTE) || (i_text_byte == CR_BYTE)
                            || (i_text_byte == LF_BYTE);
        o_q_data.quote = (i_text_byte == QUOTE_BYTE);
        o_q_data.sep = (i_text_byte == r_sep);
    end

endmodule

`default_nettype wire

@@ hw/rtl/cft_queue.sv @@
// Short queue of classified bytes between front and back end.
// Depends on cft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cft_queue
    import cft_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire t_class i_wr_data,
    input  wire logic   i_rd,
    output t_class      o_rd_data,
    output t_q_status   o_status
);

    t_class              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]     r_wp;
    logic [Q_AW-1:0]     r_rp;
    logic [Q_AW:0]       r_cnt;
    logic                wr_ok;
    logic                rd_ok;

    assign o_status.full = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign wr_ok = i_wr & ~o_status.full;
    assign rd_ok = i_rd & ~o_status.empty;
    assign o_rd_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cft_back.sv @@
// Back end: field state machine and two-entry result buffer.
// Depends on cft_pkg; drains cft_queue.
`timescale 1ns / 1ps
`default_nettype none

module cft_back
    import cft_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q_status,
    input  wire t_class    i_q_data,
    output logic           o_q_rd,
    output logic           empty,
    input  wire logic      pop,
    output t_result        o_res
);

    typedef enum logic [2:0] {
        PH_START,
        PH_UNQ,
        PH_QUO,
        PH_QQ,
        PH_DROP
    } t_phase;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    t_result          r_obuf [2];
    logic             r_owp;
    logic             r_orp;
    logic [1:0]       r_ocnt;
    logic             emit;
    t_result          res;
    logic             len_full;
    logic             out_pop;
    logic             take;
    logic             do_emit;

    assign empty = (r_ocnt == 2'd0);
    assign out_pop = pop & ~empty;
    assign take = ~i_q_status.empty & ((r_ocnt != 2'd2) | out_pop);
    assign o_q_rd = take;
    assign do_emit = take & emit;
    assign o_res = r_obuf[r_orp];
    assign len_full = (r_len >= LEN_W'(MAX_LEN));

    always_comb begin
        n_phase = r_phase;
        n_len = r_len;
        emit = 1'b0;
        res.kind = KIND_END;
        res.field_byte = 8'd0;
        res.status = ST_MORE;
        res.field_length = r_len[FL_W-1:0];
        case (r_phase)
            PH_UNQ: begin
                if (i_q_data.line_end) begin
                    emit = 1'b1;
                    res.status = ST_LINE;
                    n_phase = PH_START;
                    n_len = '0;
                end else if (i_q_data.sep) begin
                    emit = 1'b1;
                    n_phase = PH_START;
                    n_len = '0;
                end else if (len_full) begin
                    emit = 1'b1;
                    res.status = ST_LONG;
                    n_phase = PH_DROP;
                    n_len = '0;
                end else begin
                    emit = 1'b1;
                    n_len = r_len + 1'b1;
                    res.kind = KIND_DATA;
                    res.field_byte = i_q_data.text;
                    res.field_length = n_len[FL_W-1:0];
                end
            end
            PH_QUO: begin
                if (i_q_data.line_end) begin
                    emit = 1'b1;
                    res.status = ST_QUOTE;
                    n_phase = PH_START;
                    n_len = '0;
                end else if (i_q_data.quote) begin
                    n_phase = PH_QQ;
                end else if (len_full) begin
                    emit = 1'b1;
                    res.status = ST_QUOTE;
                    n_phase = PH_DROP;
                    n_len = '0;
                end else begin
                    emit = 1'b1;
                    n_len = r_len + 1'b1;
                    res.kind = KIND_DATA;
                    res.field_byte = i_q_data.text;
                    res.field_length = n_len[FL_W-1:0];
                end
            end
            PH_QQ: begin
                emit = 1'b1;
                n_len = '0;
                if (i_q_data.quote && !len_full) begin
                    n_phase = PH_QUO;
                    n_len = r_len + 1'b1;
                    res.kind = KIND_DATA;
                    res.field_byte = i_q_data.text;
                    res.field_length = n_len[FL_W-1:0];
                end else if (i_q_data.line_end) begin
                    res.status = ST_LINE;
                    n_phase = PH_START;
                end else if (i_q_data.sep) begin
                    n_phase = PH_START;
                end else begin
                    res.status = ST_LONG;
                    n_phase = PH_DROP;
                end
            end
            PH_DROP: begin
                if (i_q_data.line_end) begin
                    n_phase = PH_START;
                    n_len = '0;
                end
            end
            default: begin
                n_len = '0;
                res.field_length = '0;
                if (i_q_data.line_end) begin
                    emit = 1'b1;
                    res.status = ST_LINE;
                    n_phase = PH_START;
                end else if (i_q_data.quote) begin
                    n_phase = PH_QUO;
                end else if (i_q_data.sep) begin
                    emit = 1'b1;
                    n_phase = PH_START;
                end else begin
                    emit = 1'b1;
                    n_phase = PH_UNQ;
                    n_len = LEN_W'(1);
                    res.kind = KIND_DATA;
                    res.field_byte = i_q_data.text;
                    res.field_length = FL_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_obuf[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_len <= '0;
            r_owp <= 1'b0;
            r_orp <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_len <= n_len;
            end
            if (do_emit) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            if (do_emit && !out_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (out_pop && !do_emit) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/csv_field_tokenizer_unit.sv @@
// CSV field tokenizer top level: front end, classified-byte queue, back end.
// Depends on cft_pkg, cft_front, cft_queue, cft_back.
// Path: a byte is classified, written to the classified-byte queue, then registered in the result buffer.
// Throughput: one byte per cycle unless the result buffer is full and no result is popped.
// Reset (synchronous, active low): queues empty, separator back to comma, field start.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer_unit
    import cft_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      i_text_byte,
    output logic                 empty,
    input  wire logic            pop,
    output logic                 o_kind,
    output logic [7:0]           o_field_byte,
    output logic [1:0]           o_status,
    output logic [FL_W-1:0]      o_field_length,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [7:0]      i_cfg_separator
);

    t_q_status q_status;
    logic      q_wr;
    t_class    q_wr_data;
    logic      q_rd;
    t_class    q_rd_data;
    t_result   res;

    cft_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_text_byte     (i_text_byte),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_separator (i_cfg_separator),
        .i_q_status      (q_status),
        .o_q_wr          (q_wr),
        .o_q_data        (q_wr_data)
    );

    cft_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_status  (q_status)
    );

    cft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_rd_data),
        .o_q_rd     (q_rd),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res)
    );

    assign o_kind = res.kind;
    assign o_field_byte = res.field_byte;
    assign o_status = res.status;
    assign o_field_length = res.field_length;

endmodule

`default_nettype wire

@@ hw/rtl/cft_checker.sv @@
// Port-level checks of the CSV field tokenizer, bound to the top level.
// Depends on cft_pkg and csv_field_tokenizer_unit.
`timescale 1ns / 1ps
`default_nettype none

module cft_checker
    import cft_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            empty,
    input wire logic            pop,
    input wire logic            o_kind,
    input wire logic [7:0]      o_field_byte,
    input wire logic [1:0]      o_status,
    input wire logic [FL_W-1:0] o_field_length
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_DATA) |-> (o_status == ST_MORE && o_field_length != '0))
        else $error("data transfer with status or zero length");

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_END) |-> (o_field_byte == 8'd0))
        else $error("end-of-field transfer with nonzero byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_field_byte)
                              && $stable(o_status) && $stable(o_field_length)))
        else $error("stalled result changed");

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_kind         (o_kind),
    .o_field_byte   (o_field_byte),
    .o_status       (o_status),
    .o_field_length (o_field_length)
);

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for csv_field_tokenizer_unit: drives byte streams and separator
// writes, predicts every field byte and end-of-field token, and compares them in order.
// Depends on cft_pkg and the csv_field_tokenizer_unit RTL.
`timescale 1ns / 1ps

module testbench;
    import cft_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES = 20;
    localparam int LONG_HOLD = 80;
    localparam int PHASE_BYTES = 12;

    typedef enum logic [2:0] {PH_START, PH_UNQ, PH_QUO, PH_QQ, PH_DROP} t_phase;
    typedef enum logic [2:0] {OP_BYTE, OP_CFG, OP_DRAIN, OP_HOLD, OP_CALM} t_op;

    typedef struct {
        t_op        op;
        logic [7:0] value;
    } t_text_item;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            push = 1'b0;
    logic            full;
    logic [7:0]      i_text_byte = 8'd0;
    logic            empty;
    logic            pop = 1'b0;
    logic            o_kind;
    logic [7:0]      o_field_byte;
    logic [1:0]      o_status;
    logic [FL_W-1:0] o_field_length;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [7:0]      i_cfg_separator = 8'd0;

    t_text_item  text_q[$];
    t_result     token_q[$];
    t_text_item  cur;
    int          mismatch_count = 0;
    bit          byte_xfer = 1'b0;
    bit          cfg_xfer = 1'b0;
    bit          busy = 1'b0;
    bit          calm = 1'b0;
    int          send_gap = 0;
    int          settle = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          rx_wait = 0;
    int          phase_bytes = 0;
    logic [7:0]  gen_sep = SEP_RESET;

    t_phase      tok_phase = PH_START;
    int unsigned tok_len = 0;
    logic [7:0]  tok_sep = SEP_RESET;

    csv_field_tokenizer_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_field_byte   (o_field_byte),
        .o_status       (o_status),
        .o_field_length (o_field_length),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_separator(i_cfg_separator)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_eol(logic [7:0] b);
        return b == NUL_BYTE || b == CR_BYTE || b == LF_BYTE;
    endfunction

    function automatic void close_field(input logic [1:0] st, input t_phase nxt,
                                        output t_result r);
        r.kind = KIND_END;
        r.field_byte = 8'd0;
        r.status = st;
        r.field_length = tok_len[FL_W-1:0];
        tok_phase = nxt;
        tok_len = 0;
    endfunction

    function automatic void field_data(input logic [7:0] b, output t_result r);
        tok_len++;
        r.kind = KIND_DATA;
        r.field_byte = b;
        r.status = '0;
        r.field_length = tok_len[FL_W-1:0];
    endfunction

    function automatic bit tokenize_byte(input logic [7:0] b, output t_result r);
        bit at_limit;
        at_limit = tok_len >= MAX_LEN;
        r = '0;
        case (tok_phase)
            PH_UNQ: begin
                if (is_eol(b)) close_field(ST_LINE, PH_START, r);
                else if (b == tok_sep) close_field(ST_MORE, PH_START, r);
                else if (at_limit) close_field(ST_LONG, PH_DROP, r);
                else field_data(b, r);
                return 1'b1;
            end
            PH_QUO: begin
                if (is_eol(b)) begin
                    close_field(ST_QUOTE, PH_START, r);
                    return 1'b1;
                end
                if (b == QUOTE_BYTE) begin
                    tok_phase = PH_QQ;
                    return 1'b0;
                end
                if (at_limit) close_field(ST_QUOTE, PH_DROP, r);
                else field_data(b, r);
                return 1'b1;
            end
            PH_QQ: begin
                if (b == QUOTE_BYTE && !at_limit) begin
                    tok_phase = PH_QUO;
                    field_data(b, r);
                end else if (is_eol(b)) close_field(ST_LINE, PH_START, r);
                else if (b == tok_sep) close_field(ST_MORE, PH_START, r);
                else close_field(ST_LONG, PH_DROP, r);
                return 1'b1;
            end
            PH_DROP: begin
                if (is_eol(b)) begin
                    tok_phase = PH_START;
                    tok_len = 0;
                end
                return 1'b0;
            end
            default: begin
                tok_len = 0;
                if (is_eol(b)) begin
                    close_field(ST_LINE, PH_START, r);
                    return 1'b1;
                end
                if (b == QUOTE_BYTE) begin
                    tok_phase = PH_QUO;
                    return 1'b0;
                end
                if (b == tok_sep) begin
                    close_field(ST_MORE, PH_START, r);
                    return 1'b1;
                end
                tok_phase = PH_UNQ;
                field_data(b, r);
                return 1'b1;
            end
        endcase
    endfunction

    task automatic put(input t_op op, input logic [7:0] v);
        t_text_item it;
        it.op = op;
        it.value = v;
        text_q.push_back(it);
    endtask

    task automatic put_byte(input logic [7:0] b);
        put(OP_BYTE, b);
        phase_bytes++;
    endtask

    function automatic logic [7:0] plain_byte(bit allow_sep);
        logic [7:0] b;
        b = $urandom_range(0, 255);
        while (is_eol(b) || b == QUOTE_BYTE || (!allow_sep && b == gen_sep))
            b = $urandom_range(0, 255);
        return b;
    endfunction

    task automatic add_long(input bit quoted, input int len, input bit dq_tail);
        if (quoted) put_byte(QUOTE_BYTE);
        repeat (len) put_byte(plain_byte(quoted));
        if (dq_tail) begin
            put_byte(QUOTE_BYTE);
            put_byte(QUOTE_BYTE);
            put_byte("t");
        end else if (quoted) put_byte(QUOTE_BYTE);
        put_byte(LF_BYTE);
    endtask

    task automatic add_line();
        int nf;
        int k;
        int n;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) put_byte(gen_sep);
            k = $urandom_range(0, 9);
            n = $urandom_range(0, 6);
            if (k <= 5) begin
                repeat (n) put_byte(plain_byte(1'b0));
            end else if (k <= 7) begin
                put_byte(QUOTE_BYTE);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            put_byte(QUOTE_BYTE);
                            put_byte(QUOTE_BYTE);
                        end
                        1: put_byte(is_eol(gen_sep) ? plain_byte(1'b1) : gen_sep);
                        default: put_byte(plain_byte(1'b1));
                    endcase
                end
                put_byte(QUOTE_BYTE);
            end else if (k == 8) begin
                put_byte(QUOTE_BYTE);
                repeat (n) put_byte(plain_byte(1'b1));
                if ($urandom_range(0, 1)) begin
                    put_byte(QUOTE_BYTE);
                    put_byte(plain_byte(1'b0));
                    repeat ($urandom_range(0, 4)) put_byte(plain_byte(1'b1) ^ 8'h80);
                end
            end else begin
                repeat (n + 1) put_byte($urandom_range(0, 255));
            end
        end
        case ($urandom_range(0, 2))
            0: put_byte(NUL_BYTE);
            1: put_byte(CR_BYTE);
            default: put_byte(LF_BYTE);
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        byte_xfer = 1'b0;
        cfg_xfer = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                got.kind = o_kind;
                got.field_byte = o_field_byte;
                got.status = o_status;
                got.field_length = o_field_length;
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected token, expected none, actual kind %0d",
                             $time, got.kind,
                             " byte %0d status %0d length %0d",
                             got.field_byte, got.status, got.field_length);
                    mismatch_count++;
                end else begin
                    want = token_q.pop_front();
                    if (got.kind !== want.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
                        mismatch_count++;
                    end
                    if (got.field_byte !== want.field_byte) begin
                        $display("%0t: field_byte expected %0d actual %0d",
                                 $time, want.field_byte, got.field_byte);
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.field_length !== want.field_length) begin
                        $display("%0t: field_length expected %0d actual %0d",
                                 $time, want.field_length, got.field_length);
                        mismatch_count++;
                    end
                end
            end
            if (push && !full) begin
                byte_xfer = 1'b1;
                if (tokenize_byte(i_text_byte, want)) token_q.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_xfer = 1'b1;
                tok_sep = i_cfg_separator;
            end
        end
    end

    always @(negedge i_clk) begin
        logic nxt_push;
        logic nxt_cfg;
        if (i_rst_n) begin
            nxt_push = push;
            nxt_cfg = i_cfg_valid;
            if (byte_xfer || cfg_xfer) begin
                busy = 1'b0;
                if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 8);
            end
            if (byte_xfer) nxt_push = 1'b0;
            if (cfg_xfer) nxt_cfg = 1'b0;
            if (byte_xfer || push || token_q.size() != 0) settle = 0;
            else settle++;
            if (!busy) begin
                if (send_gap > 0) send_gap--;
                else if (text_q.size() > 0) begin
                    cur = text_q.pop_front();
                    busy = 1'b1;
                end
            end
            if (busy) begin
                case (cur.op)
                    OP_BYTE: begin
                        nxt_push = 1'b1;
                        i_text_byte <= cur.value;
                    end
                    OP_CFG: begin
                        if (settle >= SETTLE_CYCLES && !nxt_cfg) begin
                            nxt_cfg = 1'b1;
                            i_cfg_separator <= cur.value;
                        end
                    end
                    OP_DRAIN: begin
                        if (settle >= SETTLE_CYCLES) busy = 1'b0;
                    end
                    OP_HOLD: begin
                        hold_reqs++;
                        busy = 1'b0;
                    end
                    default: begin
                        calm = 1'b1;
                        busy = 1'b0;
                    end
                endcase
            end
            push <= nxt_push;
            i_cfg_valid <= nxt_cfg;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                rx_wait = LONG_HOLD;
            end else if (rx_wait == 0 && !calm && $urandom_range(0, 9) == 0) begin
                rx_wait = $urandom_range(1, 8);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] phase_sep [7];
        phase_sep[0] = SEP_RESET;
        phase_sep[1] = 8'd255;
        phase_sep[2] = NUL_BYTE;
        phase_sep[3] = QUOTE_BYTE;
        phase_sep[4] = 8'd9;
        phase_sep[5] = $urandom_range(0, 255);
        phase_sep[6] = SEP_RESET;
        for (int p = 0; p < 7; p++) begin
            gen_sep = phase_sep[p];
            put(OP_CFG, gen_sep);
            if (p == 0) begin
                put_byte(LF_BYTE);
                put_byte("a"); put_byte(gen_sep); put_byte("b"); put_byte(gen_sep);
                put_byte(CR_BYTE);
                put_byte(8'hFF); put_byte(8'h01); put_byte(NUL_BYTE);
                put_byte(QUOTE_BYTE); put_byte("x"); put_byte(QUOTE_BYTE);
                put_byte(QUOTE_BYTE); put_byte("y"); put_byte(QUOTE_BYTE);
                put_byte(gen_sep); put_byte(QUOTE_BYTE); put_byte(LF_BYTE);
                put_byte(QUOTE_BYTE); put_byte("a"); put_byte(QUOTE_BYTE);
                put_byte("c"); put_byte(gen_sep); put_byte(LF_BYTE);
                put_byte(QUOTE_BYTE); put_byte("z"); put_byte(QUOTE_BYTE); put_byte(CR_BYTE);
                put_byte(gen_sep); put_byte(LF_BYTE);
                add_long(1'b0, MAX_LEN + 1, 1'b0);
                add_long(1'b1, MAX_LEN + 1, 1'b0);
            end
            if (p == 1) put(OP_HOLD, 8'd0);
            if (p == 3) add_long(1'b1, MAX_LEN, 1'b1);
            if (p == 6) put(OP_CALM, 8'd0);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                add_line();
                if (p == 4 && phase_bytes >= PHASE_BYTES / 2
                    && phase_bytes < PHASE_BYTES / 2 + 30) begin
                    put(OP_DRAIN, 8'd0);
                    phase_bytes = PHASE_BYTES / 2 + 30;
                end
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || busy || token_q.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
